/* sv/bss_pkg.sv */
// Shared types and constants of the byte sequence stripper.
package bss_pkg;

   localparam int MAX_PATTERN = 8;
   localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = $clog2(MAX_PATTERN);
   localparam int PATTERN_W   = 8 * MAX_PATTERN;

   // register indexes of the configuration port
   localparam logic CSR_PATTERN = 1'b0;
   localparam logic CSR_LENGTH  = 1'b1;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [PATTERN_W-1:0] pattern;
      logic [FILL_W-1:0]    length;    // effective length, 1 to MAX_PATTERN
   } cfg_type;

   // bytes leaving the window for one input word, slot 0 newest
   typedef struct packed {
      logic [MAX_PATTERN-1:0]           mask;
      logic [MAX_PATTERN-1:0][7:0]      bytes;
      logic                             end_flag;
      logic                             marker;
   } batch_type;

endpackage

/* sv/bss_req_if.sv */
// Input channel: one byte of the string per word.
interface bss_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, data_byte, end_of_input, input ready);
   modport sink (input valid, data_byte, end_of_input, output ready);
endinterface

/* sv/bss_rsp_if.sv */
// Result channel: one kept byte or an empty end marker per word.
interface bss_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       end_of_output;
   logic       run_last;

   modport source (output valid, out_byte, byte_valid, end_of_output, run_last,
                   input ready);
   modport sink (input valid, out_byte, byte_valid, end_of_output, run_last,
                 output ready);
endinterface

/* sv/bss_csr_if.sv */
// Configuration write channel: register index and write data.
interface bss_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [63:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* sv/bss_csr.sv */
// Configuration registers and the clamped pattern length.
module bss_csr (
   input  logic          clock,
   input  logic          reset,
   bss_csr_if.sink       csr_bus,
   output bss_pkg::cfg_type cfg
);
   import bss_pkg::*;

   logic [PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [3:0]           length_ff, length_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PATTERN: pattern_in = csr_bus.data[PATTERN_W-1:0];
            CSR_LENGTH:  length_in  = csr_bus.data[3:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= 4'd1;
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   // zero acts as one, anything above the window depth as the depth
   always_comb begin
      cfg.pattern = pattern_ff;
      if (length_ff == 4'd0) begin
         cfg.length = FILL_W'(1);
      end else if ({1'b0, length_ff} > 5'(MAX_PATTERN)) begin
         cfg.length = FILL_W'(MAX_PATTERN);
      end else begin
         cfg.length = FILL_W'(length_ff);
      end
   end

endmodule

/* sv/bss_window.sv */
// Match window: inserts a byte, marks matches and picks the bytes it releases.
module bss_window (
   input  logic               clock,
   input  logic               reset,
   input  bss_pkg::cfg_type   cfg,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               end_of_input,
   output bss_pkg::batch_type batch
);
   import bss_pkg::*;

   // slot 0 holds the newest byte
   byte_type [MAX_PATTERN-1:0] win_ff, win_s;
   logic [MAX_PATTERN-1:0]     marks_ff, marks_in, marks_s, marks_h;
   logic [FILL_W-1:0]          fill_ff, fill_in, fill_s, keep;
   logic [MAX_PATTERN-1:0]     cmp_ok, emit;
   logic [IDX_W-1:0]           pidx [MAX_PATTERN];
   logic                       hit;

   always_comb begin
      win_s[0]   = data_byte;
      marks_s[0] = 1'b0;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         win_s[i]   = win_ff[i-1];
         marks_s[i] = marks_ff[i-1];
      end
      fill_s = fill_ff + FILL_W'(1);

      // newest byte lines up with the last pattern byte
      for (int j = 0; j < MAX_PATTERN; j++) begin
         pidx[j]   = IDX_W'(cfg.length - FILL_W'(1) - FILL_W'(j));
         cmp_ok[j] = (FILL_W'(j) >= cfg.length) ||
                     (win_s[j] == cfg.pattern[pidx[j]*8 +: 8]);
      end
      hit = (fill_s >= cfg.length) && (&cmp_ok);

      keep = end_of_input ? FILL_W'(0) : cfg.length - FILL_W'(1);

      for (int i = 0; i < MAX_PATTERN; i++) begin
         marks_h[i]  = marks_s[i] | (hit && (FILL_W'(i) < cfg.length));
         emit[i]     = (FILL_W'(i) < fill_s) && (FILL_W'(i) >= keep) &&
                       !marks_h[i] && (win_s[i] != 8'd0);
         marks_in[i] = marks_h[i] && (FILL_W'(i) < keep);
      end
      fill_in = (fill_s < keep) ? fill_s : keep;

      batch.mask     = emit;
      batch.bytes    = win_s;
      batch.end_flag = end_of_input;
      batch.marker   = end_of_input && (emit == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff <= '0;
         fill_ff  <= '0;
      end else if (accept) begin
         marks_ff <= marks_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_s;
      end
   end

endmodule

/* sv/bss_drain.sv */
// Result register: holds released bytes and hands them out oldest first.
module bss_drain (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bss_pkg::batch_type batch,
   bss_rsp_if.source          rsp_bus,
   output logic               free
);
   import bss_pkg::*;

   logic [MAX_PATTERN-1:0]     mask_ff, mask_in, sel_oh, rest;
   byte_type [MAX_PATTERN-1:0] bytes_ff;
   logic                       end_ff;
   logic                       marker_ff, marker_in;
   logic [IDX_W-1:0]           sel;
   logic                       batch_last, pop;

   // oldest pending byte sits in the highest set slot
   always_comb begin
      sel = '0;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (mask_ff[i]) begin
            sel = IDX_W'(i);
         end
      end
      sel_oh     = MAX_PATTERN'(1) << sel;
      rest       = mask_ff & ~sel_oh;
      batch_last = marker_ff || (rest == '0);
   end

   assign rsp_bus.valid         = (|mask_ff) || marker_ff;
   assign rsp_bus.out_byte      = marker_ff ? 8'd0 : bytes_ff[sel];
   assign rsp_bus.byte_valid    = !marker_ff;
   assign rsp_bus.run_last      = batch_last;
   assign rsp_bus.end_of_output = end_ff && batch_last;

   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign free = !rsp_bus.valid || (pop && batch_last);

   always_comb begin
      mask_in   = mask_ff;
      marker_in = marker_ff;
      if (load) begin
         mask_in   = batch.mask;
         marker_in = batch.marker;
      end else if (pop) begin
         mask_in   = rest;
         marker_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff   <= '0;
         marker_ff <= 1'b0;
      end else begin
         mask_ff   <= mask_in;
         marker_ff <= marker_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= batch.bytes;
         end_ff   <= batch.end_flag;
      end
   end

endmodule

/* sv/byte_sequence_stripper.sv */
// Byte sequence stripper: removes a configured byte pattern from a byte stream.
//
// Each accepted byte enters a window of the last pattern_length bytes, matches of
// the pattern mark their bytes for removal, and bytes that no later match can cover
// move to the result register in the same cycle; zero bytes are matched but never
// output. A result is registered and appears in the cycle after the byte that
// releases it. While every byte releases at most one result and the output is not
// stalled, the block takes one byte per cycle. A byte that releases n results (the
// final byte of a string, or the first byte after the length is shortened) stalls
// the input until the result register has handed out the last of them, one word
// per cycle; a final byte that leaves nothing gives one empty end marker. There is
// no clearing pass after reset. Write the registers only while the block is idle.
module byte_sequence_stripper (
   input  logic      clock,
   input  logic      reset,
   bss_req_if.sink   req_bus,
   bss_rsp_if.source rsp_bus,
   bss_csr_if.sink   csr_bus
);
   import bss_pkg::*;

   cfg_type   cfg;
   batch_type batch;
   logic      accept;
   logic      free;

   assign req_bus.ready = free;
   assign accept        = req_bus.valid && free;

   bss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   bss_window u_window (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .accept       (accept),
      .data_byte    (req_bus.data_byte),
      .end_of_input (req_bus.end_of_input),
      .batch        (batch)
   );

   bss_drain u_drain (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .batch   (batch),
      .rsp_bus (rsp_bus),
      .free    (free)
   );

endmodule

/* sv/bss_checker.sv */
// Port checker for the byte sequence stripper and its bind.
module bss_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       byte_valid,
   input logic       end_of_output,
   input logic       run_last
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) &&
      $stable(byte_valid) && $stable(end_of_output) && $stable(run_last))
      else $error("result word changed while stalled");

   // the final byte of a string always yields a result next cycle
   a_end_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_end |=> rsp_valid)
      else $error("no result after final byte");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !byte_valid |-> end_of_output && run_last && (out_byte == 8'd0))
      else $error("malformed empty end marker");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && end_of_output |-> run_last)
      else $error("end of output without run last");

   // no new byte is taken while a result of an earlier one is still not its last
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || (rsp_ready && run_last))
      else $error("input taken while results pending");

endmodule

bind byte_sequence_stripper bss_checker u_bss_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_end       (req_bus.end_of_input),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .out_byte      (rsp_bus.out_byte),
   .byte_valid    (rsp_bus.byte_valid),
   .end_of_output (rsp_bus.end_of_output),
   .run_last      (rsp_bus.run_last)
);
